FILE: design/key_count_table_macros.svh
// Assertion macros used by the checker of the key count table.
// Self-contained: no other file is needed.
`ifndef KEY_COUNT_TABLE_MACROS_SVH
`define KEY_COUNT_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/kct_pkg.sv
// Types and constants of the key count table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package kct_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam int KEY_W = 32;
    localparam int CNT_W = 32;
    localparam int AMT_W = 16;

    typedef enum logic [2:0] {
        STAT_RAISED    = 3'd0,
        STAT_INSERTED  = 3'd1,
        STAT_REDUCED   = 3'd2,
        STAT_DELETED   = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_FULL      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

    typedef struct packed {
        logic             we;
        logic             valid;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_upd;

endpackage

`default_nettype wire

FILE: design/kct_store.sv
// Entry store of the key count table: one write port, one registered read port.
// Depends on kct_pkg.
`default_nettype none

module kct_store
    import kct_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_wr          i_wr,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: design/kct_alu.sv
// Update unit of the key count table: one shared adder serves both the
// saturating add and the compare-and-subtract. Depends on kct_pkg.
`default_nettype none

module kct_alu
    import kct_pkg::*;
(
    input  logic             i_action,
    input  logic             i_hit,
    input  logic             i_free,
    input  logic [CNT_W-1:0] i_count,
    input  logic [AMT_W-1:0] i_amount,
    output t_upd             o_upd
);

    logic [CNT_W-1:0] w_amt_ext;
    logic [CNT_W-1:0] w_opb;
    logic [CNT_W:0]   w_sum;

    // For a removal the adder forms count + ~amount + 1; its carry out is
    // then set when no borrow occurred.
    assign w_amt_ext = {{(CNT_W - AMT_W){1'b0}}, i_amount};
    assign w_opb     = i_action ? ~w_amt_ext : w_amt_ext;
    assign w_sum     = {1'b0, i_count} + {1'b0, w_opb} + {{CNT_W{1'b0}}, i_action};

    always_comb begin
        o_upd.we     = 1'b0;
        o_upd.valid  = 1'b0;
        o_upd.status = STAT_FULL;
        o_upd.count  = '0;
        priority if (!i_action && i_hit) begin
            o_upd.we     = 1'b1;
            o_upd.valid  = 1'b1;
            o_upd.status = STAT_RAISED;
            o_upd.count  = w_sum[CNT_W] ? {CNT_W{1'b1}} : w_sum[CNT_W-1:0];
        end else if (!i_action && i_free) begin
            o_upd.we     = 1'b1;
            o_upd.valid  = 1'b1;
            o_upd.status = STAT_INSERTED;
            o_upd.count  = w_amt_ext;
        end else if (!i_action) begin
            o_upd.status = STAT_FULL;
        end else if (!i_hit) begin
            o_upd.status = STAT_NOT_FOUND;
        end else if (w_sum[CNT_W] && (w_sum[CNT_W-1:0] != '0)) begin
            o_upd.we     = 1'b1;
            o_upd.valid  = 1'b1;
            o_upd.status = STAT_REDUCED;
            o_upd.count  = w_sum[CNT_W-1:0];
        end else begin
            o_upd.we     = 1'b1;
            o_upd.status = STAT_DELETED;
        end
    end

endmodule

`default_nettype wire

FILE: design/key_count_table.sv
// Top level of the key count table: sequencer, key comparator and result register.
// Depends on kct_pkg, kct_store and kct_alu.
//
// The block keeps up to ENTRIES signed keys, each with a 32-bit count.
// A request is one beat on the command channel: it is taken at a rising
// edge where start is high and busy is low, carrying i_action (add or
// remove), i_key and i_amount. Busy then stays high while a single key
// comparator walks the entry store, one entry a cycle, through its
// registered read port; it records the matching entry and the lowest
// free entry as it goes.
// After the walk, state S_LAST drains the read register and state S_UPDATE
// updates the chosen entry through the shared adder. The result beat (o_status,
// o_count_after) is then shown for exactly one cycle with o_valid high.
// Busy falls in that same cycle, so the edge that takes the result beat may
// also take the next request; no request is taken while the walk is under way.
// The receiver has no way to stall a result beat; it must take it when
// o_valid is high.
// After reset the block clears the valid flag of every entry, one entry a
// cycle, holding busy high until the last entry is cleared before it takes a request.
`default_nettype none

module key_count_table
    import kct_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_action,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic        [AMT_W-1:0] i_amount,
    output logic                    o_valid,
    output logic        [2:0]       o_status,
    output logic        [CNT_W-1:0] o_count_after
);

    t_state r_state;
    t_state n_state;

    // Request held for the duration of its walk.
    logic             r_action;
    logic [KEY_W-1:0] r_key;
    logic [AMT_W-1:0] r_amount;

    // Walk address, and the index of the entry now in the read register.
    logic [IDX_W-1:0] r_addr;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;

    // What the walk found.
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [CNT_W-1:0] r_hit_cnt;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;

    // Result beat.
    logic             r_valid;
    t_status          r_status;
    logic [CNT_W-1:0] r_count;

    logic             w_accept;
    logic             w_rd_en;
    t_mem_wr          w_wr;
    t_entry           w_rd_data;
    t_upd             w_upd;
    logic             w_key_eq;

    assign w_accept = start && (r_state == S_IDLE);

    kct_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    kct_alu u_alu (
        .i_action (r_action),
        .i_hit    (r_hit),
        .i_free   (r_free),
        .i_count  (r_hit_cnt),
        .i_amount (r_amount),
        .o_upd    (w_upd)
    );

    // The one key comparator, used once for every entry in the walk.
    assign w_key_eq = (w_rd_data.key == r_key);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == LAST_IDX) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Store control and handshake outputs.
    always_comb begin
        w_wr    = '0;
        w_rd_en = 1'b0;
        busy    = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                w_wr.we   = 1'b1;
                w_wr.addr = r_addr;
            end
            S_IDLE: begin
                busy = 1'b0;
            end
            S_SCAN: begin
                w_rd_en = 1'b1;
            end
            S_LAST: begin
                w_rd_en = 1'b0;
            end
            S_UPDATE: begin
                w_wr.we         = w_upd.we;
                w_wr.addr       = r_hit ? r_hit_idx : r_free_idx;
                w_wr.data.valid = w_upd.valid;
                w_wr.data.key   = r_key;
                w_wr.data.count = w_upd.count;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == S_SCAN);
            r_valid   <= (r_state == S_UPDATE);

            if ((r_state == S_CLEAR) || (r_state == S_SCAN)) begin
                r_addr <= IDX_W'(r_addr + 1'b1);
            end else if (w_accept) begin
                r_addr <= '0;
            end

            if (w_accept) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else if (r_cmp_vld) begin
                if (w_rd_data.valid && w_key_eq) begin
                    r_hit <= 1'b1;
                end
                if (!w_rd_data.valid) begin
                    r_free <= 1'b1;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;

        if (w_accept) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_amount <= i_amount;
        end

        if (r_cmp_vld) begin
            if (w_rd_data.valid && w_key_eq) begin
                r_hit_idx <= r_cmp_idx;
                r_hit_cnt <= w_rd_data.count;
            end
            // Only the lowest-numbered free entry is kept.
            if (!w_rd_data.valid && !r_free) begin
                r_free_idx <= r_cmp_idx;
            end
        end

        if (r_state == S_UPDATE) begin
            r_status <= w_upd.status;
            r_count  <= w_upd.count;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_count_after = r_count;

endmodule

`default_nettype wire

FILE: design/kct_chk.sv
// Port-level checker for the key count table, bound to the top level.
// Depends on kct_pkg and key_count_table_macros.svh.
`default_nettype none
`include "key_count_table_macros.svh"

module kct_chk
    import kct_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire logic             o_valid,
    input  wire logic [2:0]       o_status,
    input  wire logic [CNT_W-1:0] o_count_after
);

    logic w_accept;
    logic w_no_count;
    logic w_reduced;

    assign w_accept   = start && !busy;
    assign w_no_count = o_valid && (o_status == STAT_DELETED || o_status == STAT_NOT_FOUND ||
                                    o_status == STAT_FULL);
    assign w_reduced  = o_valid && (o_status == STAT_REDUCED);

    // A result beat never carries a code outside the status list.
    `KCT_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_valid, o_status <= STAT_FULL, "bad status")

    // Deleted, absent and refused requests report a zero count.
    `KCT_ASSERT_NOW(a_zero_count, i_clk, i_rst_n, w_no_count, o_count_after == '0, "count not zero")

    // A reduced count is never zero: that case deletes the entry.
    `KCT_ASSERT_NOW(a_reduced_nonzero, i_clk, i_rst_n, w_reduced, o_count_after != '0, "zero count")

    // An accepted request occupies the block for the cycles that follow.
    `KCT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, busy && !o_valid, "not busy")

    // Every result beat closes a busy stretch.
    `KCT_ASSERT_NOW(a_result_after_busy, i_clk, i_rst_n, o_valid, $past(busy) && !busy, "no work")

endmodule

bind key_count_table kct_chk u_kct_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_count_after (o_count_after)
);

`default_nettype wire

FILE: tb/key_count_table_tb.sv
// Self-checking testbench for the key count table: a shadow copy of the table predicts
// the outcome of every request beat and each result beat is checked against it.
// Depends on kct_pkg and the key_count_table RTL only.
`default_nettype none

module key_count_table_tb
    import kct_pkg::*;
();

    // Request operations as carried on i_action.
    localparam bit OP_ADD    = 1'b0;
    localparam bit OP_REMOVE = 1'b1;

    // The slowest correct run is about 1750 requests, plus the sender's gaps and the
    // clearing pass. This limit sits several times above that.
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;

    // One expected result beat.
    typedef struct {
        t_status          status;
        logic [CNT_W-1:0] count;
    } count_outcome_t;

    // The shadow table tracks every slot exactly as the block should.
    // It works out the outcome of each accepted request and holds those outcomes in
    // order until the matching result beats arrive.
    class table_shadow;
        bit               used [ENTRIES];
        logic [KEY_W-1:0] held_key [ENTRIES];
        logic [CNT_W-1:0] held_count [ENTRIES];
        count_outcome_t   due [$];
        int               failures;

        function int pending();
            return due.size();
        endfunction

        function void note_request(bit act, logic [KEY_W-1:0] k, logic [AMT_W-1:0] amt);
            int             hit;
            int             spare;
            logic [CNT_W:0] sum;
            count_outcome_t o;
            hit     = -1;
            spare   = -1;
            o.count = '0;
            // The match and the lowest free slot are both found in one walk.
            for (int i = 0; i < ENTRIES; i++) begin
                if (used[i] && held_key[i] == k && hit < 0)
                    hit = i;
                if (!used[i] && spare < 0)
                    spare = i;
            end
            if (act == OP_ADD) begin
                if (hit >= 0) begin
                    // The count saturates at all ones rather than wrapping.
                    sum = {1'b0, held_count[hit]} + (CNT_W + 1)'(amt);
                    held_count[hit] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
                    o.status = STAT_RAISED;
                    o.count  = held_count[hit];
                end else if (spare >= 0) begin
                    used[spare]       = 1'b1;
                    held_key[spare]   = k;
                    held_count[spare] = CNT_W'(amt);
                    o.status = STAT_INSERTED;
                    o.count  = CNT_W'(amt);
                end else begin
                    o.status = STAT_FULL;
                end
            end else begin
                if (hit < 0) begin
                    o.status = STAT_NOT_FOUND;
                end else if (held_count[hit] > CNT_W'(amt)) begin
                    held_count[hit] = held_count[hit] - CNT_W'(amt);
                    o.status = STAT_REDUCED;
                    o.count  = held_count[hit];
                end else begin
                    used[hit] = 1'b0;
                    o.status  = STAT_DELETED;
                end
            end
            due.push_back(o);
        endfunction

        function void check_result(logic [2:0] st, logic [CNT_W-1:0] cnt);
            count_outcome_t o;
            if (due.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result beat: status %0d count %0h", st, cnt);
            end else begin
                o = due.pop_front();
                if (st !== o.status || cnt !== o.count) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("result mismatch: status exp %0d got %0d, count exp %0h got %0h",
                                 o.status, st, o.count, cnt);
                end
            end
        endfunction
    endclass

    logic                    i_clk    = 1'b0;
    logic                    i_rst_n  = 1'b0;
    logic                    start    = 1'b0;
    logic                    i_action = OP_ADD;
    logic        [KEY_W-1:0] i_key    = '0;
    logic        [AMT_W-1:0] i_amount = '0;
    logic                    busy;
    logic                    o_valid;
    logic        [2:0]       o_status;
    logic        [CNT_W-1:0] o_count_after;

    table_shadow shadow = new();
    int          cycles = 0;

    key_count_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_amount      (i_amount),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_count_after (o_count_after)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog: a hung block or a lost result beat ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Monitor. Everything is driven by nonblocking assignment, so the values read here
    // are those that stood before the edge. A result beat is checked before a request
    // taken at the same edge is noted; the older expectation is first in line anyway.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1)
                shadow.check_result(o_status, o_count_after);
            if (start === 1'b1 && busy === 1'b0)
                shadow.note_request(i_action, i_key, i_amount);
        end
    end

    // Present one request beat and hold it until the block takes it. Called at a
    // rising edge, and returns at the edge that accepted the beat, so start is never
    // given two assignments in one time step.
    task automatic send_request(input bit act, input logic [KEY_W-1:0] k,
                                input logic [AMT_W-1:0] amt);
        start    <= 1'b1;
        i_action <= act;
        i_key    <= k;
        i_amount <= amt;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
    endtask

    // Sender gap. The key and amount are scrambled so that stale values on the bus
    // carry no meaning. The gap is counted from the first cycle in which the block
    // is free, so every paused cycle is one where a beat could go in.
    task automatic pause_sender(input int n);
        start    <= 1'b0;
        i_key    <= $urandom;
        i_amount <= AMT_W'($urandom);
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        repeat (n - 1) @(posedge i_clk);
    endtask

    // Hold off until every outstanding result has come back. The count is read at
    // the falling edge, well clear of the monitor, and the task returns on a rising
    // edge.
    task automatic wait_for_drain();
        start <= 1'b0;
        do
            @(negedge i_clk);
        while (shadow.pending() != 0);
        @(posedge i_clk);
    endtask

    initial begin
        logic [KEY_W-1:0] pool [20];
        int               add_pct;
        bit               calm;
        bit               act;
        logic [KEY_W-1:0] k;
        logic [AMT_W-1:0] amt;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The block first runs its clearing pass; send_request simply
        // waits for busy to fall.
        send_request(OP_REMOVE, 32'h0000_0005, 16'd1);      // remove on an empty table
        send_request(OP_ADD,    32'h0000_0000, 16'd0);      // new key with zero amount
        send_request(OP_ADD,    32'h7FFF_FFFF, 16'hFFFF);
        send_request(OP_ADD,    32'h8000_0000, 16'd1);
        send_request(OP_ADD,    32'hFFFF_FFFF, 16'd5);
        send_request(OP_ADD,    32'hFFFF_FFFF, 16'hFFFF);   // count raised
        send_request(OP_REMOVE, 32'hFFFF_FFFF, 16'd3);      // count reduced
        send_request(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_REMOVE, 32'hFFFF_FFFF, 16'd2);      // amount equal to count: deleted
        send_request(OP_REMOVE, 32'h0000_0000, 16'd0);      // zero count, zero amount: deleted
        // Fill every remaining slot, then try one more key.
        for (int n = 0; n < ENTRIES - 2; n++)
            send_request(OP_ADD, KEY_W'(1000 + n * 7919), AMT_W'(n));
        send_request(OP_ADD,    32'h1234_5678, 16'd9);      // table full
        // Freeing the slot of the largest key must make it the lowest free slot.
        send_request(OP_REMOVE, 32'h7FFF_FFFF, 16'hFFFF);
        send_request(OP_ADD,    32'hCAFE_0001, 16'h8000);
        // Saturation of a count needs more than 65536 adds at the largest amount,
        // which lies beyond a run of this length; the shadow table still models it.

        wait_for_drain();

        // Random part: episodes over a small pool of keys, so that hits, fills and
        // deletions are frequent. Each episode leans towards adds or removes by a
        // different amount, and about one request in twenty uses a fresh random key.
        for (int ep = 0; ep < 17; ep++) begin
            calm    = (ep == 6);
            add_pct = $urandom_range(35, 80);
            foreach (pool[j])
                pool[j] = $urandom;
            pool[$urandom_range(0, 19)] = 32'h8000_0000;
            pool[$urandom_range(0, 19)] = 32'h7FFF_FFFF;
            pool[$urandom_range(0, 19)] = 32'h0000_0000;
            for (int n = 0; n < 100; n++) begin
                act = ($urandom_range(0, 99) >= add_pct) ? OP_REMOVE : OP_ADD;
                k   = ($urandom_range(0, 19) == 0) ? KEY_W'($urandom)
                                                   : pool[$urandom_range(0, 19)];
                case ($urandom_range(0, 9))
                    0:       amt = '0;
                    1:       amt = '1;
                    2, 3:    amt = AMT_W'($urandom);
                    default: amt = AMT_W'($urandom_range(1, 6));
                endcase
                send_request(act, k, amt);
                // About seven beats in a hundred are followed by a gap; one episode
                // runs back to back throughout.
                if (!calm && $urandom_range(0, 99) < 7)
                    pause_sender($urandom_range(1, 20));
            end
            if (ep % 4 == 3)
                wait_for_drain();
        end

        // Let the last result beats come home, then allow for the block's latency.
        wait_for_drain();
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (shadow.failures == 0 && shadow.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
